FILE: sv/lj_pkg.sv
// Shared types and helpers for the Lennard-Jones pair force pipeline.
`default_nettype none
package lj_pkg;

    localparam logic [63:0] UMAX     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN_MAG = 64'h8000_0000_0000_0000;

    typedef enum logic {
        REQ_LOAD    = 1'b0,
        REQ_COMPUTE = 1'b1
    } t_req_kind;

    typedef struct packed {
        logic               req_type;
        logic        [3:0]  type_i;
        logic        [3:0]  type_j;
        logic signed [31:0] pos_ix;
        logic signed [31:0] pos_iy;
        logic signed [31:0] pos_iz;
        logic signed [31:0] pos_jx;
        logic signed [31:0] pos_jy;
        logic signed [31:0] pos_jz;
        logic        [31:0] entry_sigma;
        logic        [31:0] entry_epsilon;
        logic        [47:0] entry_cutoff_sq;
    } t_req;

    typedef struct packed {
        logic               in_range;
        logic signed [63:0] force_x;
        logic signed [63:0] force_y;
        logic signed [63:0] force_z;
        logic signed [63:0] half_energy;
        logic signed [63:0] vir_xx;
        logic signed [63:0] vir_yy;
        logic signed [63:0] vir_zz;
        logic signed [63:0] vir_xy;
        logic signed [63:0] vir_xz;
        logic signed [63:0] vir_yz;
    } t_res;

    // state that travels down the pipeline with each item
    typedef struct packed {
        logic             valid;
        logic             in_range;
        logic [2:0]       dneg;
        logic [2:0][31:0] dmag;
        logic [63:0]      r2;
        logic [31:0]      eps;
        logic [63:0]      q;
        logic [63:0]      q3;
        logic             eneg;
        logic [63:0]      emag;
        logic             tneg;
        logic [2:0]       fneg;
        logic [2:0][63:0] fmag;
    } t_side;

    function automatic logic [63:0] f_clamp(input logic neg, input logic [63:0] mag);
        if (neg) begin
            return (mag > SMIN_MAG) ? SMIN_MAG : mag;
        end
        return (mag > SMAX) ? SMAX : mag;
    endfunction

    function automatic logic [63:0] f_to_bits(input logic neg, input logic [63:0] mag);
        logic [63:0] m;
        m = f_clamp(neg, mag);
        return neg ? (~m + 64'd1) : m;
    endfunction

endpackage
`default_nettype wire

FILE: sv/lj_delay.sv
// Stallable delay line for the per-item side state.
`default_nettype none
module lj_delay import lj_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire t_side i_side,
    output t_side      o_side
);

    t_side r_pipe [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_pipe[k].valid <= 1'b0;
            end
        end else if (i_en) begin
            r_pipe[0] <= i_side;
            for (int k = 1; k < DEPTH; k++) begin
                r_pipe[k] <= r_pipe[k-1];
            end
        end
    end

    assign o_side = r_pipe[DEPTH-1];

endmodule
`default_nettype wire

FILE: sv/lj_qmul.sv
// Two-stage unsigned Q32.32 multiplier, truncating and saturating.
`default_nettype none
module lj_qmul (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic      [63:0] o_p
);

    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic [63:0]  r_p;
    logic [127:0] w_full;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= 64'(i_a[31:0])  * 64'(i_b[31:0]);
            r_p01 <= 64'(i_a[31:0])  * 64'(i_b[63:32]);
            r_p10 <= 64'(i_a[63:32]) * 64'(i_b[31:0]);
            r_p11 <= 64'(i_a[63:32]) * 64'(i_b[63:32]);
        end
    end

    assign w_full = {64'd0, r_p00} + {32'd0, r_p01, 32'd0}
                  + {32'd0, r_p10, 32'd0} + {r_p11, 64'd0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= (|w_full[127:96]) ? 64'hFFFF_FFFF_FFFF_FFFF : w_full[95:32];
        end
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

FILE: sv/lj_qdiv.sv
// Pipelined restoring divider: (num << 32) / den, one quotient bit per stage.
`default_nettype none
module lj_qdiv import lj_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic [63:0] i_num,
    input  wire logic [63:0] i_den,
    input  wire t_side       i_side,
    output logic      [63:0] o_quo,
    output t_side            o_side
);

    localparam int STEPS = 64;

    logic [63:0] r_rem  [STEPS+1];
    logic [63:0] r_quo  [STEPS+1];
    logic [63:0] r_den  [STEPS+1];
    logic [31:0] r_nlo  [STEPS+1];
    logic        r_sat  [STEPS+1];
    t_side       r_side [STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side[0].valid <= 1'b0;
        end else if (i_en) begin
            r_rem[0]  <= {32'd0, i_num[63:32]};
            r_quo[0]  <= '0;
            r_den[0]  <= i_den;
            r_nlo[0]  <= i_num[31:0];
            r_sat[0]  <= ({32'd0, i_num[63:32]} >= i_den);
            r_side[0] <= i_side;
        end
    end

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        logic        w_bit;
        logic [64:0] w_t;
        logic        w_ge;

        if (s < 32) begin : g_hi
            assign w_bit = r_nlo[s][31-s];
        end else begin : g_lo
            assign w_bit = 1'b0;
        end

        assign w_t  = {r_rem[s], w_bit};
        assign w_ge = (w_t >= {1'b0, r_den[s]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[s+1].valid <= 1'b0;
            end else if (i_en) begin
                r_rem[s+1]  <= w_ge ? 64'(w_t - {1'b0, r_den[s]}) : w_t[63:0];
                r_quo[s+1]  <= {r_quo[s][62:0], w_ge};
                r_den[s+1]  <= r_den[s];
                r_nlo[s+1]  <= r_nlo[s];
                r_sat[s+1]  <= r_sat[s];
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_quo  = r_sat[STEPS] ? UMAX : r_quo[STEPS];
    assign o_side = r_side[STEPS];

endmodule
`default_nettype wire

FILE: sv/lennard_jones_pair_force_core.sv
// Lennard-Jones 12-6 pair force pipeline with type-pair parameter table.
//
// Request channel (i_req_valid / o_req_ready / i_req): a load item writes
// sigma, epsilon and squared cutoff for table entry (type_i, type_j) and
// gives no result; a compute item gives exactly one result item.
// Result channel (o_res_valid / i_res_ready / o_res): force on atom i, half
// pair energy and six virial components, or zeros with in_range low.
// Throughput: one item per cycle while the receiver does not stall. The
// pipeline is built from the two 65-stage dividers, whose stages after
// the input register give one quotient bit each, and 2-stage multipliers.
// A table entry written by one item is seen by the very next item.
// Reset clears all valid bits in the pipeline; table contents are kept and
// an entry must be written before it is used.
// When a result is shown and the receiver stalls, the whole pipeline holds
// and o_req_ready drops; nothing is lost or repeated.
`default_nettype none
module lennard_jones_pair_force_core import lj_pkg::*; #(
    parameter int NUM_TYPES = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_req i_req,
    output logic      o_res_valid,
    input  wire logic i_res_ready,
    output t_res      o_res
);

    localparam int TAB_DEPTH = NUM_TYPES * NUM_TYPES;
    localparam int IDX_W     = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;

    logic              en, acc, w_tok;
    logic [IDX_W-1:0]  w_idx;
    logic [32:0]       w_d [3];
    logic [111:0]      mem [TAB_DEPTH];
    logic [111:0]      r_tab;

    t_side       r_s0, r_s1, r_s2, r_s3;
    t_side       n_s0, n_s1, n_s3;
    logic        r_tok0, r_tok1, r_tok2;
    logic [63:0] r_sq1 [3];
    logic [63:0] r_s2q1, r_s2q2, r_s2q3;
    logic [47:0] r_cut1, r_cut2;
    logic [65:0] r_sum2;

    t_side       w_d1, w_d1q, w_d2, w_d3, w_d3q, w_d4, w_d5, w_d6, w_d7, w_d8;
    logic [63:0] w_q, w_q2, w_q3, w_q6, w_pe, w_pt, w_k;
    logic [63:0] w_f [3];
    logic [63:0] w_v [6];

    t_side       r_e_side, n_e_side, r_f_side, n_f_side, r_g_side, n_g_side;
    logic [63:0] r_ediff, n_ediff, r_tdiff, n_tdiff, r_tk, n_tk;
    logic [64:0] w_t2;
    logic [63:0] w_t2s, w_eps64;
    logic [64:0] w_e2;
    logic [68:0] w_t24;
    logic        r_out_valid;
    t_res        r_res, n_res;

    assign en          = !r_out_valid || i_res_ready;
    assign o_req_ready = en;
    assign acc         = i_req_valid && en;

    assign w_tok = (int'(i_req.type_i) < NUM_TYPES) && (int'(i_req.type_j) < NUM_TYPES);
    assign w_idx = IDX_W'(int'(i_req.type_i) * NUM_TYPES + int'(i_req.type_j));

    assign w_d[0] = {i_req.pos_ix[31], i_req.pos_ix} - {i_req.pos_jx[31], i_req.pos_jx};
    assign w_d[1] = {i_req.pos_iy[31], i_req.pos_iy} - {i_req.pos_jy[31], i_req.pos_jy};
    assign w_d[2] = {i_req.pos_iz[31], i_req.pos_iz} - {i_req.pos_jz[31], i_req.pos_jz};

    always_ff @(posedge i_clk) begin
        if (acc && (i_req.req_type == REQ_LOAD) && w_tok) begin
            mem[w_idx] <= {i_req.entry_sigma, i_req.entry_epsilon, i_req.entry_cutoff_sq};
        end
        if (en) begin
            r_tab <= mem[w_idx];
        end
    end

    always_comb begin
        n_s0       = '0;
        n_s0.valid = acc && (i_req.req_type == REQ_COMPUTE);
        for (int a = 0; a < 3; a++) begin
            n_s0.dneg[a] = w_d[a][32];
            n_s0.dmag[a] = w_d[a][32] ? 32'(-w_d[a]) : w_d[a][31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else if (en) begin
            r_s0   <= n_s0;
            r_tok0 <= w_tok;
        end
    end

    always_comb begin
        n_s1     = r_s0;
        n_s1.eps = r_tab[79:48];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (en) begin
            r_s1 <= n_s1;
            for (int a = 0; a < 3; a++) begin
                r_sq1[a] <= 64'(r_s0.dmag[a]) * 64'(r_s0.dmag[a]);
            end
            r_s2q1 <= 64'(r_tab[111:80]) * 64'(r_tab[111:80]);
            r_cut1 <= r_tab[47:0];
            r_tok1 <= r_tok0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (en) begin
            r_s2   <= r_s1;
            r_sum2 <= 66'(r_sq1[0]) + 66'(r_sq1[1]) + 66'(r_sq1[2]);
            r_s2q2 <= r_s2q1;
            r_cut2 <= r_cut1;
            r_tok2 <= r_tok1;
        end
    end

    always_comb begin
        n_s3          = r_s2;
        n_s3.r2       = r_sum2[63:0];
        n_s3.in_range = r_tok2 && (r_sum2[65:64] == 2'd0) && (r_sum2[63:0] != 64'd0)
                        && (r_sum2[63:0] < {r_cut2, 16'd0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.valid <= 1'b0;
        end else if (en) begin
            r_s3   <= n_s3;
            r_s2q3 <= r_s2q2;
        end
    end

    lj_qdiv u_div_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_num(r_s2q3), .i_den(r_s3.r2), .i_side(r_s3),
        .o_quo(w_q), .o_side(w_d1)
    );

    always_comb begin
        w_d1q   = w_d1;
        w_d1q.q = w_q;
    end

    lj_qmul u_mul_q2 (.i_clk(i_clk), .i_en(en), .i_a(w_q), .i_b(w_q), .o_p(w_q2));
    lj_delay #(.DEPTH(2)) u_dly_q2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_side(w_d1q), .o_side(w_d2)
    );

    lj_qmul u_mul_q3 (.i_clk(i_clk), .i_en(en), .i_a(w_q2), .i_b(w_d2.q), .o_p(w_q3));
    lj_delay #(.DEPTH(2)) u_dly_q3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_side(w_d2), .o_side(w_d3)
    );

    always_comb begin
        w_d3q    = w_d3;
        w_d3q.q3 = w_q3;
    end

    lj_qmul u_mul_q6 (.i_clk(i_clk), .i_en(en), .i_a(w_q3), .i_b(w_q3), .o_p(w_q6));
    lj_delay #(.DEPTH(2)) u_dly_q6 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_side(w_d3q), .o_side(w_d4)
    );

    assign w_t2  = {w_q6, 1'b0};
    assign w_t2s = w_t2[64] ? UMAX : w_t2[63:0];

    always_comb begin
        n_e_side      = w_d4;
        n_e_side.eneg = (w_q6 < w_d4.q3);
        n_ediff       = n_e_side.eneg ? (w_d4.q3 - w_q6) : (w_q6 - w_d4.q3);
        n_e_side.tneg = (w_t2s < w_d4.q3);
        n_tdiff       = n_e_side.tneg ? (w_d4.q3 - w_t2s) : (w_t2s - w_d4.q3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_side.valid <= 1'b0;
        end else if (en) begin
            r_e_side <= n_e_side;
            r_ediff  <= n_ediff;
            r_tdiff  <= n_tdiff;
        end
    end

    assign w_eps64 = {16'd0, r_e_side.eps, 16'd0};

    lj_qmul u_mul_e (.i_clk(i_clk), .i_en(en), .i_a(w_eps64), .i_b(r_ediff), .o_p(w_pe));
    lj_qmul u_mul_t (.i_clk(i_clk), .i_en(en), .i_a(w_eps64), .i_b(r_tdiff), .o_p(w_pt));
    lj_delay #(.DEPTH(2)) u_dly_e (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_side(r_e_side), .o_side(w_d5)
    );

    assign w_e2  = {w_pe, 1'b0};
    assign w_t24 = {5'd0, w_pt} * 69'd24;

    always_comb begin
        n_f_side      = w_d5;
        n_f_side.emag = w_e2[64] ? UMAX : w_e2[63:0];
        n_tk          = (|w_t24[68:64]) ? UMAX : w_t24[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_side.valid <= 1'b0;
        end else if (en) begin
            r_f_side <= n_f_side;
            r_tk     <= n_tk;
        end
    end

    lj_qdiv u_div_k (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_num(r_tk), .i_den(r_f_side.r2), .i_side(r_f_side),
        .o_quo(w_k), .o_side(w_d6)
    );

    for (genvar a = 0; a < 3; a++) begin : g_force
        lj_qmul u_mul_f (
            .i_clk(i_clk), .i_en(en), .i_a(w_k),
            .i_b({16'd0, w_d6.dmag[a], 16'd0}), .o_p(w_f[a])
        );
    end

    lj_delay #(.DEPTH(2)) u_dly_f (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_side(w_d6), .o_side(w_d7)
    );

    always_comb begin
        n_g_side = w_d7;
        for (int a = 0; a < 3; a++) begin
            n_g_side.fneg[a] = w_d7.tneg ^ w_d7.dneg[a];
            n_g_side.fmag[a] = f_clamp(n_g_side.fneg[a], w_f[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_side.valid <= 1'b0;
        end else if (en) begin
            r_g_side <= n_g_side;
        end
    end

    lj_qmul u_mul_vxx (.i_clk(i_clk), .i_en(en), .i_a(r_g_side.fmag[0]),
                       .i_b({16'd0, r_g_side.dmag[0], 16'd0}), .o_p(w_v[0]));
    lj_qmul u_mul_vyy (.i_clk(i_clk), .i_en(en), .i_a(r_g_side.fmag[1]),
                       .i_b({16'd0, r_g_side.dmag[1], 16'd0}), .o_p(w_v[1]));
    lj_qmul u_mul_vzz (.i_clk(i_clk), .i_en(en), .i_a(r_g_side.fmag[2]),
                       .i_b({16'd0, r_g_side.dmag[2], 16'd0}), .o_p(w_v[2]));
    lj_qmul u_mul_vxy (.i_clk(i_clk), .i_en(en), .i_a(r_g_side.fmag[0]),
                       .i_b({16'd0, r_g_side.dmag[1], 16'd0}), .o_p(w_v[3]));
    lj_qmul u_mul_vxz (.i_clk(i_clk), .i_en(en), .i_a(r_g_side.fmag[0]),
                       .i_b({16'd0, r_g_side.dmag[2], 16'd0}), .o_p(w_v[4]));
    lj_qmul u_mul_vyz (.i_clk(i_clk), .i_en(en), .i_a(r_g_side.fmag[1]),
                       .i_b({16'd0, r_g_side.dmag[2], 16'd0}), .o_p(w_v[5]));

    lj_delay #(.DEPTH(2)) u_dly_v (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_side(r_g_side), .o_side(w_d8)
    );

    always_comb begin
        n_res = '0;
        if (w_d8.in_range) begin
            n_res.in_range    = 1'b1;
            n_res.force_x     = f_to_bits(w_d8.fneg[0], w_d8.fmag[0]);
            n_res.force_y     = f_to_bits(w_d8.fneg[1], w_d8.fmag[1]);
            n_res.force_z     = f_to_bits(w_d8.fneg[2], w_d8.fmag[2]);
            n_res.half_energy = f_to_bits(w_d8.eneg, w_d8.emag);
            n_res.vir_xx      = f_to_bits(w_d8.fneg[0] ^ w_d8.dneg[0], w_v[0]);
            n_res.vir_yy      = f_to_bits(w_d8.fneg[1] ^ w_d8.dneg[1], w_v[1]);
            n_res.vir_zz      = f_to_bits(w_d8.fneg[2] ^ w_d8.dneg[2], w_v[2]);
            n_res.vir_xy      = f_to_bits(w_d8.fneg[0] ^ w_d8.dneg[1], w_v[3]);
            n_res.vir_xz      = f_to_bits(w_d8.fneg[0] ^ w_d8.dneg[2], w_v[4]);
            n_res.vir_yz      = f_to_bits(w_d8.fneg[1] ^ w_d8.dneg[2], w_v[5]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= w_d8.valid;
            r_res       <= n_res;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

endmodule
`default_nettype wire
